// ----- design/tcalc_pkg.sv -----
// Shared constants and fixed-point helpers for the triangle tangent calculator.
`timescale 1ns / 1ps

package tcalc_pkg;

   // Fractional bits of every Q-format value
   localparam int FRAC_BITS = 16;

   // Width of one floored 64-bit product, and of a difference of two such values
   localparam int FL_W  = 64 - FRAC_BITS;
   localparam int ACC_W = FL_W + 1;

   // Reciprocal quotient: floor(2^(2F) / |det|) needs 2F+1 bits
   localparam int QUO_W     = 2 * FRAC_BITS + 1;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   // Sequencer step counter
   localparam int STEP_W = 4;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // floor(p / 2^F), sign-extended to the accumulator width
   function automatic logic signed [ACC_W-1:0] floor_ext(input logic signed [63:0] p);
      logic signed [FL_W-1:0] f;
      f = p[63:FRAC_BITS];
      floor_ext = {f[FL_W-1], f};
   endfunction

   // Clamp an accumulator-width value to the 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-32:0] hi;
      hi = v[ACC_W-1:31];
      if ((&hi) || !(|hi)) sat32 = v[31:0];
      else if (v[ACC_W-1]) sat32 = SAT_MIN;
      else sat32 = SAT_MAX;
   endfunction

endpackage

// ----- design/triangle_tangent_calc.sv -----
// Triangle tangent calculator: vertex capture, shared multiplier and divider sequencer.
// First and second vertex: captured into the vertex stores, no result. Third vertex: deltas,
// determinant products, divider, reciprocal, numerator and tangent products on the one 32x32
// multiplier (a zero determinant goes straight to hand-over), then hand-over to the result
// register; the input stalls meanwhile, so a new triangle is taken only after the hand-over.
// Synchronous active-high reset clears the vertex slot, sequencer and result valid.
`timescale 1ns / 1ps

module triangle_tangent_calc (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_tangent_x,
   output logic signed [31:0] rsp_tangent_y,
   output logic signed [31:0] rsp_tangent_z,
   output logic               rsp_degenerate
);
   import tcalc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DELTA,
      S_MUL,
      S_ACC,
      S_DIV_INIT,
      S_DIV,
      S_RECIP,
      S_OUT
   } state_type;

   // Sequencer step marks
   localparam logic [STEP_W-1:0] STEP_DELTA_LAST = 4'd9;
   localparam logic [STEP_W-1:0] STEP_DET        = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LAST       = 4'd10;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(QUO_W - 1);

   // Control state
   state_type               state_ff, state_in;
   logic [1:0]              slot_ff, slot_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Vertex stores
   logic signed [31:0]      pos0_ff [3], pos0_in [3];
   logic signed [31:0]      pos1_ff [3], pos1_in [3];
   logic signed [31:0]      pos2_ff [3], pos2_in [3];
   logic signed [31:0]      tex0_ff [2], tex0_in [2];
   logic signed [31:0]      tex1_ff [2], tex1_in [2];
   logic signed [31:0]      tex2_ff [2], tex2_in [2];

   // Deltas
   logic signed [31:0]      du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [31:0]      du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [31:0]      dp1_ff [3], dp1_in [3];
   logic signed [31:0]      dp2_ff [3], dp2_in [3];

   // Multiply/accumulate and divider datapath
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]      num_ff [3], num_in [3];
   logic signed [31:0]      recip_ff, recip_in;
   logic [ACC_W-1:0]        div_ff, div_in;
   logic [ACC_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic                    neg_ff, neg_in;

   // Result register
   logic signed [31:0]      tan_ff [3], tan_in [3];
   logic                    degen_ff, degen_in;
   logic signed [31:0]      out_tan_ff [3], out_tan_in [3];
   logic                    out_degen_ff, out_degen_in;

   // Shared unit operands and results
   logic signed [31:0]      sub_a, sub_b;
   logic signed [32:0]      sub_diff;
   logic signed [31:0]      delta_val;
   logic signed [31:0]      mul_a, mul_b;
   logic signed [ACC_W-1:0] fl_prod;
   logic [ACC_W:0]          rem_shift;
   logic                    div_bit;
   logic                    rem_ge;
   logic [63:0]             quo_ext;

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tangent_x  = out_tan_ff[0];
   assign rsp_tangent_y  = out_tan_ff[1];
   assign rsp_tangent_z  = out_tan_ff[2];
   assign rsp_degenerate = out_degen_ff;

   // Delta subtractor operand select
   always_comb begin
      unique case (step_ff)
         4'd0: begin sub_a = tex1_ff[0]; sub_b = tex0_ff[0]; end
         4'd1: begin sub_a = tex1_ff[1]; sub_b = tex0_ff[1]; end
         4'd2: begin sub_a = tex2_ff[0]; sub_b = tex0_ff[0]; end
         4'd3: begin sub_a = tex2_ff[1]; sub_b = tex0_ff[1]; end
         4'd4: begin sub_a = pos1_ff[0]; sub_b = pos0_ff[0]; end
         4'd5: begin sub_a = pos1_ff[1]; sub_b = pos0_ff[1]; end
         4'd6: begin sub_a = pos1_ff[2]; sub_b = pos0_ff[2]; end
         4'd7: begin sub_a = pos2_ff[0]; sub_b = pos0_ff[0]; end
         4'd8: begin sub_a = pos2_ff[1]; sub_b = pos0_ff[1]; end
         4'd9: begin sub_a = pos2_ff[2]; sub_b = pos0_ff[2]; end
         default: begin sub_a = '0; sub_b = '0; end
      endcase
   end

   assign sub_diff  = {sub_a[31], sub_a} - {sub_b[31], sub_b};
   assign delta_val = sat32({{(ACC_W-33){sub_diff[32]}}, sub_diff});

   // Multiplier operand select
   always_comb begin
      unique case (step_ff)
         4'd0:  begin mul_a = du1_ff;    mul_b = dv2_ff;   end
         4'd1:  begin mul_a = dv1_ff;    mul_b = du2_ff;   end
         4'd2:  begin mul_a = dp1_ff[0]; mul_b = dv2_ff;   end
         4'd3:  begin mul_a = dp2_ff[0]; mul_b = dv1_ff;   end
         4'd4:  begin mul_a = dp1_ff[1]; mul_b = dv2_ff;   end
         4'd5:  begin mul_a = dp2_ff[1]; mul_b = dv1_ff;   end
         4'd6:  begin mul_a = dp1_ff[2]; mul_b = dv2_ff;   end
         4'd7:  begin mul_a = dp2_ff[2]; mul_b = dv1_ff;   end
         4'd8:  begin mul_a = num_ff[0]; mul_b = recip_ff; end
         4'd9:  begin mul_a = num_ff[1]; mul_b = recip_ff; end
         4'd10: begin mul_a = num_ff[2]; mul_b = recip_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign fl_prod = floor_ext(prod_ff);

   // Restoring divider step: dividend is 2^(2F), so only its top bit is set
   assign div_bit   = (cnt_ff == '0);
   assign rem_shift = {rem_ff, div_bit};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   assign quo_ext   = 64'(quo_ff);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pos0_in      = pos0_ff;
      pos1_in      = pos1_ff;
      pos2_in      = pos2_ff;
      tex0_in      = tex0_ff;
      tex1_in      = tex1_ff;
      tex2_in      = tex2_ff;
      du1_in       = du1_ff;
      dv1_in       = dv1_ff;
      du2_in       = du2_ff;
      dv2_in       = dv2_ff;
      dp1_in       = dp1_ff;
      dp2_in       = dp2_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      recip_in     = recip_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      tan_in       = tan_ff;
      degen_in     = degen_ff;
      out_tan_in   = out_tan_ff;
      out_degen_in = out_degen_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (slot_ff)
                  2'd1: begin
                     pos1_in = '{req_pos_x, req_pos_y, req_pos_z};
                     tex1_in = '{req_tex_u, req_tex_v};
                     slot_in = 2'd2;
                  end
                  2'd2: begin
                     pos2_in  = '{req_pos_x, req_pos_y, req_pos_z};
                     tex2_in  = '{req_tex_u, req_tex_v};
                     slot_in  = 2'd0;
                     step_in  = '0;
                     state_in = S_DELTA;
                  end
                  default: begin
                     pos0_in = '{req_pos_x, req_pos_y, req_pos_z};
                     tex0_in = '{req_tex_u, req_tex_v};
                     slot_in = 2'd1;
                  end
               endcase
            end
         end

         // One saturated delta per cycle
         S_DELTA: begin
            unique case (step_ff)
               4'd0: du1_in = delta_val;
               4'd1: dv1_in = delta_val;
               4'd2: du2_in = delta_val;
               4'd3: dv2_in = delta_val;
               4'd4: dp1_in[0] = delta_val;
               4'd5: dp1_in[1] = delta_val;
               4'd6: dp1_in[2] = delta_val;
               4'd7: dp2_in[0] = delta_val;
               4'd8: dp2_in[1] = delta_val;
               4'd9: dp2_in[2] = delta_val;
               default: ;
            endcase
            if (step_ff == STEP_DELTA_LAST) begin
               step_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         S_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_ACC;
         end

         // Fold the registered product into the accumulator
         S_ACC: begin
            unique case (step_ff) inside
               4'd0, 4'd2, 4'd4, 4'd6: acc_in = fl_prod;
               4'd1:  acc_in = acc_ff - fl_prod;
               4'd3:  num_in[0] = sat32(acc_ff - fl_prod);
               4'd5:  num_in[1] = sat32(acc_ff - fl_prod);
               4'd7:  num_in[2] = sat32(acc_ff - fl_prod);
               4'd8:  tan_in[0] = sat32(fl_prod);
               4'd9:  tan_in[1] = sat32(fl_prod);
               4'd10: tan_in[2] = sat32(fl_prod);
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_DET) state_in = S_DIV_INIT;
            else if (step_ff == STEP_LAST) state_in = S_OUT;
            else state_in = S_MUL;
         end

         // Zero determinant: degenerate result; else load |det| as divisor
         S_DIV_INIT: begin
            if (acc_ff == '0) begin
               tan_in   = '{32'sd0, 32'sd0, 32'sd0};
               degen_in = 1'b1;
               state_in = S_OUT;
            end else begin
               degen_in = 1'b0;
               neg_in   = acc_ff[ACC_W-1];
               div_in   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end

         // One quotient bit per cycle
         S_DIV: begin
            rem_in = rem_ge ? ACC_W'(rem_shift - {1'b0, div_ff}) : ACC_W'(rem_shift);
            quo_in = {quo_ff[QUO_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_RECIP;
         end

         // Apply the sign and saturate the reciprocal
         S_RECIP: begin
            if (!neg_ff) begin
               recip_in = (quo_ext > 64'h7FFF_FFFF) ? SAT_MAX : signed'(quo_ext[31:0]);
            end else begin
               recip_in = (quo_ext > 64'h8000_0000) ? SAT_MIN : signed'(-quo_ext[31:0]);
            end
            state_in = S_MUL;
         end

         // Hand over to the result register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_tan_in   = tan_ff;
               out_degen_in = degen_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= 2'd0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos0_ff      <= pos0_in;
      pos1_ff      <= pos1_in;
      pos2_ff      <= pos2_in;
      tex0_ff      <= tex0_in;
      tex1_ff      <= tex1_in;
      tex2_ff      <= tex2_in;
      du1_ff       <= du1_in;
      dv1_ff       <= dv1_in;
      du2_ff       <= du2_in;
      dv2_ff       <= dv2_in;
      dp1_ff       <= dp1_in;
      dp2_ff       <= dp2_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      recip_ff     <= recip_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      tan_ff       <= tan_in;
      degen_ff     <= degen_in;
      out_tan_ff   <= out_tan_in;
      out_degen_ff <= out_degen_in;
   end

`ifndef ASSERT_OFF
   // Third vertex of a triangle starts the delta sequence
   a_third_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && slot_ff == 2'd2) |=> (state_ff == S_DELTA))
      else $error("third vertex did not start the tangent sequence");

   // A new result only comes out of the hand-over state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result valid rose outside the hand-over state");

   // Degenerate results carry a zero tangent
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_degen_ff) |->
         (out_tan_ff[0] == '0 && out_tan_ff[1] == '0 && out_tan_ff[2] == '0))
      else $error("degenerate result with nonzero tangent");

   // Divider never runs on a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0))
      else $error("divider running with zero divisor");

   // Result valid and degenerate flag are held until the pending transfer is done
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(out_degen_ff)))
      else $error("pending result dropped or changed");
`endif

endmodule
